>>> hdl/sorted_rank_table_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted rank table
// Concurrent checks are clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_RANK_TABLE_TOP_MACROS_SVH
`define SORTED_RANK_TABLE_TOP_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define SRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define SRT_ASSERT_NEVER(lbl, cond, msg) \
  `SRT_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/srt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted rank table package
// Sizes, operation and status codes, and the control word of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

  localparam int DEPTH     = 32;
  localparam int RANK_BITS = 16;
  localparam int KEY_BITS  = 48;
  localparam int PORT_RANK_BITS = 16;
  localparam int CNT_BITS  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_TRAVERSE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TRAV
  } state_e;

  typedef struct packed {
    cell_op_e                op;
    logic [RANK_BITS-1:0]    rank;
    logic [KEY_BITS-1:0]     key;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hdl/sorted_rank_table_top.sv
// An insert or delete is carried out in EXEC once the output register is free; its result is registered.
// A request is taken only in idle, so an insert or delete leaves EXEC before the next one is taken.
// Traverse of n records: a setup step in EXEC, then one result per cycle while the output is not stalled.
// Traverse rotates the chain once per result, so each result is taken from the head cell.
// Reset clears the record count, the controller and the output valid flag only.
// Stored records are not cleared; cells above the count are never read.
// ----------------------------------------------------------------------------
// Sorted rank table top level
// Keeps up to DEPTH records in ascending rank order in a chain of cells and
// serves insert, delete by key tag and traverse requests.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_rank_table_top_macros.svh"

module sorted_rank_table_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire [1:0]                          opcode_i,
  input  wire [srt_pkg::PORT_RANK_BITS-1:0]  in_rank_i,
  input  wire [srt_pkg::KEY_BITS-1:0]        in_key_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [1:0]                         status_o,
  output logic [srt_pkg::PORT_RANK_BITS-1:0] out_rank_o,
  output logic [srt_pkg::KEY_BITS-1:0]       out_key_o,
  output logic                               last_o
);

  localparam int CB = srt_pkg::CNT_BITS;

  // Controller state and the request held while it is worked on.
  srt_pkg::state_e               state_q, state_d;
  logic [1:0]                    op_q;
  logic [srt_pkg::RANK_BITS-1:0] rank_q;
  logic [srt_pkg::KEY_BITS-1:0]  key_q;
  logic [CB-1:0]                 count_q, count_d;
  logic [CB-1:0]                 trav_q, trav_d;

  // Output register: it lets the next request in while a result waits.
  logic                               out_valid_q, out_valid_d;
  logic [1:0]                         status_q, status_d;
  logic [srt_pkg::PORT_RANK_BITS-1:0] out_rank_q, out_rank_d;
  logic [srt_pkg::KEY_BITS-1:0]       out_key_q, out_key_d;
  logic                               last_q, last_d;

  logic                          load_out;
  logic                          out_free;
  logic                          accept;
  logic                          trav_last;
  logic                          table_full;
  srt_pkg::cell_op_e             cell_op;
  srt_pkg::cell_ctl_t            ctl;
  logic [srt_pkg::RANK_BITS-1:0] head_rank;
  logic [srt_pkg::KEY_BITS-1:0]  head_key;
  logic                          found;

  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign trav_last  = trav_q == (count_q - CB'(1));
  assign table_full = count_q == CB'(srt_pkg::DEPTH);

  // The chain sees the held request; cells move only when cell_op says so.
  assign ctl.op   = cell_op;
  assign ctl.rank = rank_q;
  assign ctl.key  = key_q;

  srt_chain u_chain (
    .clk_i       (clk_i),
    .ctl_i       (ctl),
    .count_i     (count_q),
    .head_rank_o (head_rank),
    .head_key_o  (head_key),
    .found_o     (found)
  );

  // Next state. A request is taken only in idle; the unused opcode causes
  // no result and returns at once. A non-empty traverse walks the chain.
  always_comb begin
    state_d = state_q;
    case (state_q)
      srt_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = srt_pkg::ST_EXEC;
        end
      end
      srt_pkg::ST_EXEC: begin
        if (op_q != srt_pkg::OP_INSERT && op_q != srt_pkg::OP_DELETE &&
            op_q != srt_pkg::OP_TRAVERSE) begin
          state_d = srt_pkg::ST_IDLE;
        end else if (out_free) begin
          if (op_q == srt_pkg::OP_TRAVERSE && count_q != '0) begin
            state_d = srt_pkg::ST_TRAV;
          end else begin
            state_d = srt_pkg::ST_IDLE;
          end
        end
      end
      srt_pkg::ST_TRAV: begin
        if (out_free && trav_last) begin
          state_d = srt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srt_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the controller. All work waits for a free output register,
  // so the chain and the count change in the same cycle as the result loads.
  always_comb begin
    cell_op    = srt_pkg::CELL_HOLD;
    load_out   = 1'b0;
    status_d   = srt_pkg::STAT_OK;
    out_rank_d = '0;
    out_key_d  = '0;
    last_d     = 1'b1;
    count_d    = count_q;
    trav_d     = trav_q;
    case (state_q)
      srt_pkg::ST_EXEC: begin
        if (out_free) begin
          case (op_q)
            srt_pkg::OP_INSERT: begin
              load_out = 1'b1;
              if (table_full) begin
                status_d = srt_pkg::STAT_FULL;
              end else begin
                cell_op = srt_pkg::CELL_INSERT;
                count_d = count_q + CB'(1);
              end
            end
            srt_pkg::OP_DELETE: begin
              load_out = 1'b1;
              if (found) begin
                cell_op = srt_pkg::CELL_DELETE;
                count_d = count_q - CB'(1);
              end else begin
                status_d = srt_pkg::STAT_NOT_FOUND;
              end
            end
            srt_pkg::OP_TRAVERSE: begin
              trav_d = '0;
              if (count_q == '0) begin
                load_out = 1'b1;
                status_d = srt_pkg::STAT_EMPTY;
              end
            end
            default: begin
              load_out = 1'b0;
            end
          endcase
        end
      end
      srt_pkg::ST_TRAV: begin
        // The head record goes out and the occupied cells rotate by one,
        // so after the last record the table is back in its order.
        if (out_free) begin
          load_out   = 1'b1;
          out_rank_d = srt_pkg::PORT_RANK_BITS'(head_rank);
          out_key_d  = head_key;
          last_d     = trav_last;
          cell_op    = srt_pkg::CELL_ROTATE;
          trav_d     = trav_q + CB'(1);
        end
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= srt_pkg::ST_IDLE;
      count_q     <= '0;
      trav_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      trav_q      <= trav_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      rank_q <= srt_pkg::RANK_BITS'(in_rank_i);
      key_q  <= in_key_i;
    end
    if (load_out) begin
      status_q   <= status_d;
      out_rank_q <= out_rank_d;
      out_key_q  <= out_key_d;
      last_q     <= last_d;
    end
  end

  assign in_stall_o  = state_q != srt_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign out_rank_o  = out_rank_q;
  assign out_key_o   = out_key_q;
  assign last_o      = last_q;

  // The record count never passes the table size.
  `SRT_ASSERT_NEVER(a_count_bound, count_q > CB'(srt_pkg::DEPTH), "record count above depth")

  // A taken request reaches the execute state in the very next cycle.
  `SRT_ASSERT(a_accept_exec, accept |=> state_q == srt_pkg::ST_EXEC, "request not executed")

  // The count moves only as an insert or delete is carried out.
  `SRT_ASSERT(a_count_step, count_q != $past(count_q) |-> $past(state_q) == srt_pkg::ST_EXEC,
              "record count changed outside execution")

  // The traverse walk stays inside the occupied cells.
  `SRT_ASSERT(a_trav_range, state_q == srt_pkg::ST_TRAV |-> trav_q < count_q,
              "traverse index beyond record count")

endmodule

`default_nettype wire

>>> hdl/srt_cell.sv
// ----------------------------------------------------------------------------
// Sorted rank table cell
// Holds one record and moves it to or from its neighbors on command.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_cell (
  input  wire                          clk_i,
  input  srt_pkg::cell_ctl_t           ctl_i,
  input  wire                          occ_i,
  input  wire                          tail_i,
  input  wire                          gt_prev_i,
  input  wire                          hit_prev_i,
  input  wire [srt_pkg::RANK_BITS-1:0] prev_rank_i,
  input  wire [srt_pkg::KEY_BITS-1:0]  prev_key_i,
  input  wire [srt_pkg::RANK_BITS-1:0] next_rank_i,
  input  wire [srt_pkg::KEY_BITS-1:0]  next_key_i,
  input  wire [srt_pkg::RANK_BITS-1:0] head_rank_i,
  input  wire [srt_pkg::KEY_BITS-1:0]  head_key_i,
  output logic [srt_pkg::RANK_BITS-1:0] rank_o,
  output logic [srt_pkg::KEY_BITS-1:0]  key_o,
  output logic                          gt_o,
  output logic                          hit_o
);

  logic [srt_pkg::RANK_BITS-1:0] rank_q, rank_d;
  logic [srt_pkg::KEY_BITS-1:0]  key_q, key_d;
  logic                          gt;
  logic                          hit;

  assign gt  = occ_i && (rank_q > ctl_i.rank);
  assign hit = hit_prev_i || (occ_i && (key_q == ctl_i.key));

  // Records above the insert point move one place toward the tail; the first cell
  // not taken by the slide and either free or of greater rank takes the new one.
  always_comb begin
    rank_d = rank_q;
    key_d  = key_q;
    case (ctl_i.op)
      srt_pkg::CELL_INSERT: begin
        if (gt_prev_i) begin
          rank_d = prev_rank_i;
          key_d  = prev_key_i;
        end else if (gt || !occ_i) begin
          rank_d = ctl_i.rank;
          key_d  = ctl_i.key;
        end
      end
      srt_pkg::CELL_DELETE: begin
        if (hit) begin
          rank_d = next_rank_i;
          key_d  = next_key_i;
        end
      end
      srt_pkg::CELL_ROTATE: begin
        if (tail_i) begin
          rank_d = head_rank_i;
          key_d  = head_key_i;
        end else begin
          rank_d = next_rank_i;
          key_d  = next_key_i;
        end
      end
      default: begin
        rank_d = rank_q;
        key_d  = key_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    key_q  <= key_d;
  end

  assign rank_o = rank_q;
  assign key_o  = key_q;
  assign gt_o   = gt;
  assign hit_o  = hit;

endmodule

`default_nettype wire

>>> hdl/srt_chain.sv
// ----------------------------------------------------------------------------
// Sorted rank table cell chain
// A row of cells linked to both neighbors; cell zero holds the lowest rank.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_chain (
  input  wire                           clk_i,
  input  srt_pkg::cell_ctl_t            ctl_i,
  input  wire [srt_pkg::CNT_BITS-1:0]   count_i,
  output logic [srt_pkg::RANK_BITS-1:0] head_rank_o,
  output logic [srt_pkg::KEY_BITS-1:0]  head_key_o,
  output logic                          found_o
);

  logic [srt_pkg::RANK_BITS-1:0] rank_w [srt_pkg::DEPTH];
  logic [srt_pkg::KEY_BITS-1:0]  key_w  [srt_pkg::DEPTH];
  logic [srt_pkg::DEPTH-1:0]     gt_w;
  logic [srt_pkg::DEPTH-1:0]     hit_w;

  for (genvar i = 0; i < srt_pkg::DEPTH; i++) begin : g_cell
    logic                          occ;
    logic                          tail;
    logic                          gt_prev;
    logic                          hit_prev;
    logic [srt_pkg::RANK_BITS-1:0] prev_rank;
    logic [srt_pkg::KEY_BITS-1:0]  prev_key;
    logic [srt_pkg::RANK_BITS-1:0] next_rank;
    logic [srt_pkg::KEY_BITS-1:0]  next_key;

    assign occ  = srt_pkg::CNT_BITS'(i) < count_i;
    assign tail = srt_pkg::CNT_BITS'(i + 1) == count_i;

    if (i == 0) begin : g_first
      assign gt_prev   = 1'b0;
      assign hit_prev  = 1'b0;
      assign prev_rank = '0;
      assign prev_key  = '0;
    end else begin : g_inner
      assign gt_prev   = gt_w[i-1];
      assign hit_prev  = hit_w[i-1];
      assign prev_rank = rank_w[i-1];
      assign prev_key  = key_w[i-1];
    end

    if (i == srt_pkg::DEPTH - 1) begin : g_last
      assign next_rank = '0;
      assign next_key  = '0;
    end else begin : g_body
      assign next_rank = rank_w[i+1];
      assign next_key  = key_w[i+1];
    end

    srt_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl_i),
      .occ_i       (occ),
      .tail_i      (tail),
      .gt_prev_i   (gt_prev),
      .hit_prev_i  (hit_prev),
      .prev_rank_i (prev_rank),
      .prev_key_i  (prev_key),
      .next_rank_i (next_rank),
      .next_key_i  (next_key),
      .head_rank_i (rank_w[0]),
      .head_key_i  (key_w[0]),
      .rank_o      (rank_w[i]),
      .key_o       (key_w[i]),
      .gt_o        (gt_w[i]),
      .hit_o       (hit_w[i])
    );
  end

  assign head_rank_o = rank_w[0];
  assign head_key_o  = key_w[0];
  assign found_o     = hit_w[srt_pkg::DEPTH-1];

endmodule

`default_nettype wire

>>> bench/rank_table_checker.sv
// ----------------------------------------------------------------------------
// Sorted rank table checker
// Watches the request and result channels, keeps its own ordered copy of the
// table, and compares every result taken from the block with the oldest
// predicted one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rank_table_checker
  import srt_pkg::*;
(
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          req_valid_i,
  input  wire                          req_stall_i,
  input  wire [1:0]                    opcode_i,
  input  wire [PORT_RANK_BITS-1:0]     in_rank_i,
  input  wire [KEY_BITS-1:0]           in_key_i,
  input  wire                          rsp_valid_i,
  input  wire                          rsp_stall_i,
  input  wire [1:0]                    status_i,
  input  wire [PORT_RANK_BITS-1:0]     out_rank_i,
  input  wire [KEY_BITS-1:0]           out_key_i,
  input  wire                          last_i,
  output int                           mismatches_o,
  output int                           awaiting_o,
  output int                           checked_o
);

  typedef struct packed {
    status_e                   status;
    logic [PORT_RANK_BITS-1:0] rank;
    logic [KEY_BITS-1:0]       key;
    logic                      last;
  } table_result_t;

  logic [RANK_BITS-1:0] rank_mem [DEPTH];
  logic [KEY_BITS-1:0]  key_mem  [DEPTH];
  int                   occupancy;
  table_result_t        awaited [$];

  function automatic void await_result(status_e status, logic [PORT_RANK_BITS-1:0] rank,
                                       logic [KEY_BITS-1:0] key, logic last);
    table_result_t item;
    item.status = status;
    item.rank   = rank;
    item.key    = key;
    item.last   = last;
    awaited.push_back(item);
  endfunction

  // The rank argument is RANK_BITS wide; the caller casts the port value to that width.
  function automatic void place_record(logic [RANK_BITS-1:0] rank, logic [KEY_BITS-1:0] key);
    int slot;
    if (occupancy >= DEPTH) begin
      await_result(STAT_FULL, '0, '0, 1'b1);
      return;
    end
    slot = occupancy;
    for (int i = 0; i < occupancy; i++) begin
      if (rank_mem[i] > rank) begin
        slot = i;
        break;
      end
    end
    for (int i = occupancy; i > slot; i--) begin
      rank_mem[i] = rank_mem[i-1];
      key_mem[i]  = key_mem[i-1];
    end
    rank_mem[slot] = rank;
    key_mem[slot]  = key;
    occupancy++;
    await_result(STAT_OK, '0, '0, 1'b1);
  endfunction

  function automatic void remove_record(logic [KEY_BITS-1:0] key);
    for (int i = 0; i < occupancy; i++) begin
      if (key_mem[i] == key) begin
        for (int j = i; j + 1 < occupancy; j++) begin
          rank_mem[j] = rank_mem[j+1];
          key_mem[j]  = key_mem[j+1];
        end
        occupancy--;
        await_result(STAT_OK, '0, '0, 1'b1);
        return;
      end
    end
    await_result(STAT_NOT_FOUND, '0, '0, 1'b1);
  endfunction

  function automatic void list_records();
    if (occupancy == 0) begin
      await_result(STAT_EMPTY, '0, '0, 1'b1);
      return;
    end
    for (int i = 0; i < occupancy; i++)
      await_result(STAT_OK, PORT_RANK_BITS'(rank_mem[i]), key_mem[i], i + 1 == occupancy);
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      mismatches_o++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    table_result_t want;
    if (!rst_ni) begin
      occupancy = 0;
      awaited.delete();
      mismatches_o = 0;
      checked_o    = 0;
      awaiting_o   = 0;
    end else begin
      // Results are handled before requests, so a result can never be matched
      // against a prediction made at the same edge.
      if (rsp_valid_i && !rsp_stall_i) begin
        checked_o++;
        if (awaited.size() == 0) begin
          mismatches_o++;
          $display("%0t: result with nothing expected: status %0h rank %0h key %0h last %0h",
                   $time, status_i, out_rank_i, out_key_i, last_i);
        end else begin
          want = awaited.pop_front();
          compare_field("status", 64'(want.status), 64'(status_i));
          compare_field("rank", 64'(want.rank), 64'(out_rank_i));
          compare_field("key", 64'(want.key), 64'(out_key_i));
          compare_field("last", 64'(want.last), 64'(last_i));
        end
      end
      if (req_valid_i && !req_stall_i) begin
        case (opcode_i)
          OP_INSERT:   place_record(RANK_BITS'(in_rank_i), in_key_i);
          OP_DELETE:   remove_record(in_key_i);
          OP_TRAVERSE: list_records();
          default:     ;
        endcase
      end
      awaiting_o = awaited.size();
    end
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Sorted rank table testbench
// Drives insert, delete and traverse requests with random idling on both
// channels, fills and drains the table, backs the block up with a long output
// hold, and lets the checker compare every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import srt_pkg::*;

  // Number of counted requests in the random part (the unused opcode is not counted).
  localparam int ITEM_TARGET = 410;
  // Length of the one long stretch in which the receiver holds off.
  localparam int HOLD_CYCLES = 200;
  // Slowest correct run: about 500 requests, each with up to 32 results, and
  // each result waiting out the longest receiver stall plus the longest run;
  // the limit is about twice that.
  localparam int LIMIT_CYCLES = 2_000_000;
  // Quiet time at the end, sized from the table depth.
  localparam int DRAIN_CYCLES = DEPTH + 8;
  // The fourth opcode value is not an operation; the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [KEY_BITS-1:0] KEY_A = 48'h0123_4567_89ab;
  localparam logic [KEY_BITS-1:0] KEY_B = 48'h8000_0000_0001;
  localparam logic [KEY_BITS-1:0] KEY_C = 48'h5a5a_a5a5_5a5a;
  localparam logic [KEY_BITS-1:0] KEY_D = 48'hfeed_0000_beef;
  localparam logic [KEY_BITS-1:0] KEY_ONES = '1;
  localparam logic [PORT_RANK_BITS-1:0] RANK_TOP = '1;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic [1:0]                opcode_i    = '0;
  logic [PORT_RANK_BITS-1:0] in_rank_i   = '0;
  logic [KEY_BITS-1:0]       in_key_i    = '0;
  logic                      out_stall_i = 1'b0;
  wire                       in_stall_o;
  wire                       out_valid_o;
  wire [1:0]                 status_o;
  wire [PORT_RANK_BITS-1:0]  out_rank_o;
  wire [KEY_BITS-1:0]        out_key_o;
  wire                       last_o;

  int mismatches;
  int awaiting;
  int checked;

  // Stimulus controls: quiet_in and quiet_out turn idling off on one side;
  // hold_go asks the receiver for its single long hold-off.
  bit quiet_in  = 1'b0;
  bit quiet_out = 1'b0;
  bit hold_go   = 1'b0;
  bit hold_done = 1'b0;

  int cycle_count = 0;
  int requests_sent = 0;
  int full_refusals = 0;
  int delete_hits = 0;
  int empty_walks = 0;

  // Keys currently in the table, kept by the stimulus side only so that deletes
  // can aim at stored records and fill rounds know when the table is full.
  logic [KEY_BITS-1:0] live_keys [$];
  logic [KEY_BITS-1:0] key_pool  [8];

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  sorted_rank_table_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .in_rank_i   (in_rank_i),
    .in_key_i    (in_key_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .out_rank_o  (out_rank_o),
    .out_key_o   (out_key_o),
    .last_o      (last_o)
  );

  rank_table_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .req_stall_i  (in_stall_o),
    .opcode_i     (opcode_i),
    .in_rank_i    (in_rank_i),
    .in_key_i     (in_key_i),
    .rsp_valid_i  (out_valid_o),
    .rsp_stall_i  (out_stall_i),
    .status_i     (status_o),
    .out_rank_i   (out_rank_o),
    .out_key_i    (out_key_o),
    .last_i       (last_o),
    .mismatches_o (mismatches),
    .awaiting_o   (awaiting),
    .checked_o    (checked)
  );

  function automatic logic [KEY_BITS-1:0] random_key();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[KEY_BITS-1:0];
  endfunction

  // Ranks lean toward a few small values so that ties are common, with the
  // extremes mixed in.
  function automatic logic [PORT_RANK_BITS-1:0] random_rank();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return PORT_RANK_BITS'($urandom_range(0, 3));
    if (pick < 30) return '0;
    if (pick < 35) return RANK_TOP;
    return PORT_RANK_BITS'($urandom);
  endfunction

  function automatic logic [KEY_BITS-1:0] insert_key();
    if ($urandom_range(0, 9) < 3) return key_pool[$urandom_range(0, 7)];
    return random_key();
  endfunction

  // Mostly a key that is stored, sometimes a pool key or a fresh one that
  // will usually miss.
  function automatic logic [KEY_BITS-1:0] delete_key();
    int pick;
    pick = $urandom_range(0, 99);
    if (live_keys.size() > 0 && pick < 70) return live_keys[$urandom_range(0, live_keys.size() - 1)];
    if (pick < 85) return key_pool[$urandom_range(0, 7)];
    return random_key();
  endfunction

  // Gaps between requests: mostly none or short, a few long.
  function automatic int idle_length();
    int pick;
    if (quiet_in) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Offers one request and returns at the edge that takes it. The stimulus
  // side's own copy of the table contents is updated in issue order, which
  // is also the order in which the block takes requests.
  task automatic issue(logic [1:0] op, logic [PORT_RANK_BITS-1:0] rank,
                       logic [KEY_BITS-1:0] key);
    int gap;
    int hit;
    gap = idle_length();
    hit = -1;
    @(negedge clk_i);
    if (gap > 0) begin
      // While idle the payload carries noise; the block must not look at it.
      in_valid_i <= 1'b0;
      opcode_i   <= 2'($urandom);
      in_rank_i  <= PORT_RANK_BITS'($urandom);
      in_key_i   <= random_key();
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    in_rank_i  <= rank;
    in_key_i   <= key;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);

    case (op)
      OP_INSERT: begin
        if (live_keys.size() < DEPTH) live_keys.push_back(key);
        else full_refusals++;
      end
      OP_DELETE: begin
        foreach (live_keys[i])
          if (hit < 0 && live_keys[i] == key) hit = i;
        if (hit >= 0) begin
          live_keys.delete(hit);
          delete_hits++;
        end
      end
      OP_TRAVERSE: if (live_keys.size() == 0) empty_walks++;
      default: ;
    endcase
    if (op != OP_UNUSED) requests_sent++;
  endtask

  // Waits with no request offered until the checker has seen every result.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (awaiting == 0);
  endtask

  // Receiver: alternating runs of taking and stalling, mostly short stalls,
  // a few long ones, and the single long hold-off when the stimulus asks.
  initial begin : receiver
    int left;
    bit stalling;
    left = 0;
    stalling = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        stalling  = 1'b1;
        left      = HOLD_CYCLES;
      end else if (left > 0) begin
        left--;
      end else if (quiet_out || stalling) begin
        stalling = 1'b0;
        left     = quiet_out ? 4 : $urandom_range(0, 12);
      end else begin
        stalling = 1'b1;
        left     = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
      out_stall_i <= stalling;
    end
  end

  initial begin : timeout
    wait (cycle_count >= LIMIT_CYCLES);
    $display("sorted_rank_table_top: mismatch");
    $finish;
  end

  initial begin : stimulus
    int round;
    int pick;
    key_pool[0] = KEY_A;
    key_pool[1] = KEY_B;
    key_pool[2] = KEY_C;
    key_pool[3] = KEY_D;
    for (int i = 4; i < 8; i++) key_pool[i] = random_key();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Traverse and delete on an empty table come first, then
    // extreme ranks and keys, ties on rank that must keep arrival order, a
    // duplicate key where delete must take the first one in table order, a
    // key that is absent, and the unused opcode with every bit set.
    issue(OP_TRAVERSE, '0, '0);
    issue(OP_DELETE, '0, KEY_A);
    issue(OP_INSERT, '0, '0);
    issue(OP_INSERT, RANK_TOP, KEY_ONES);
    issue(OP_INSERT, 16'd5, KEY_A);
    issue(OP_INSERT, 16'd5, KEY_B);
    issue(OP_INSERT, 16'd5, KEY_A);
    issue(OP_INSERT, '0, KEY_C);
    issue(OP_TRAVERSE, RANK_TOP, KEY_ONES);
    issue(OP_DELETE, RANK_TOP, KEY_A);
    issue(OP_DELETE, '0, KEY_D);
    issue(OP_UNUSED, RANK_TOP, KEY_ONES);
    issue(OP_TRAVERSE, '0, '0);
    issue(OP_DELETE, '0, KEY_ONES);
    issue(OP_DELETE, '0, '0);
    issue(OP_INSERT, RANK_TOP, KEY_B);
    issue(OP_TRAVERSE, '0, '0);
    issue(OP_DELETE, '0, KEY_A);
    issue(OP_DELETE, '0, KEY_B);
    issue(OP_DELETE, '0, KEY_B);
    issue(OP_DELETE, '0, KEY_C);
    issue(OP_TRAVERSE, '0, '0);
    settle();

    // Random part, in rounds. The first rounds are fixed so that the table is
    // filled past full, drained past empty, and backed up by the long hold.
    requests_sent = 0;
    round = 0;
    while (requests_sent < ITEM_TARGET) begin
      pick = (round < 3) ? round : $urandom_range(0, 9);
      quiet_in  = ($urandom_range(0, 4) == 0);
      quiet_out = ($urandom_range(0, 4) == 0);
      case (pick)
        0, 3, 4: begin
          // Fill until full, then a few inserts that must be refused.
          while (live_keys.size() < DEPTH) issue(OP_INSERT, random_rank(), insert_key());
          repeat ($urandom_range(1, 3)) issue(OP_INSERT, random_rank(), insert_key());
          issue(OP_TRAVERSE, random_rank(), random_key());
        end
        1, 5: begin
          // Drain to empty with an occasional miss, then act on the empty table.
          while (live_keys.size() > 0) begin
            if ($urandom_range(0, 9) == 0) issue(OP_DELETE, random_rank(), random_key());
            else issue(OP_DELETE, random_rank(), live_keys[$urandom_range(0, live_keys.size() - 1)]);
          end
          issue(OP_DELETE, random_rank(), delete_key());
          issue(OP_TRAVERSE, random_rank(), random_key());
        end
        2: begin
          // The receiver holds off while requests keep coming back to back,
          // so the block fills and stalls its input; then wait for it all.
          quiet_in  = 1'b1;
          quiet_out = 1'b0;
          hold_go   = 1'b1;
          repeat (24) begin
            if ($urandom_range(0, 3) == 0) issue(OP_TRAVERSE, random_rank(), random_key());
            else issue(OP_INSERT, random_rank(), insert_key());
          end
          settle();
        end
        9: begin
          // Noise: ignored opcodes and deletes that mostly miss.
          repeat ($urandom_range(4, 10)) begin
            if ($urandom_range(0, 1) == 0) begin
              issue(OP_UNUSED, PORT_RANK_BITS'($urandom), random_key());
            end else begin
              issue(OP_DELETE, PORT_RANK_BITS'($urandom), random_key());
            end
          end
        end
        default: begin
          repeat ($urandom_range(10, 30)) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) issue(OP_INSERT, random_rank(), insert_key());
            else if (pick < 75) issue(OP_DELETE, random_rank(), delete_key());
            else if (pick < 94) issue(OP_TRAVERSE, random_rank(), random_key());
            else issue(OP_UNUSED, PORT_RANK_BITS'($urandom), random_key());
          end
        end
      endcase
      round++;
    end

    quiet_in  = 1'b0;
    quiet_out = 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run: %0d random requests after the directed ones; %0d inserts refused on a full table,",
             requests_sent, full_refusals);
    $display("%0d deletes that hit, %0d empty traversals, %0d results checked, long hold %0s.",
             delete_hits, empty_walks, checked, hold_done ? "applied" : "not applied");
    if (mismatches == 0) begin
      $display("sorted_rank_table_top: match");
    end else begin
      $display("sorted_rank_table_top: mismatch");
    end
    $finish;
  end

endmodule
